[sv/rds_pkg.sv]
package rds_pkg;

  localparam int DIR_W  = 16;
  localparam int NRM_W  = 17;
  localparam int IOR_W  = 14;
  localparam int NIC_W  = 30;
  localparam int DISC_W = 56;
  localparam int R_W    = DISC_W / 2;
  localparam int MAG_W  = 30;
  localparam int SUM_W  = 62;
  localparam int LEN_W  = SUM_W / 2;
  localparam int NUM_W  = 46;
  localparam int Q_W    = 15;
  localparam int LANES  = 3;

  localparam logic [Q_W-1:0] Q_ONE = 15'd16384;

  typedef struct packed {
    logic en;
    logic valid;
  } ctl_t;

  typedef struct packed {
    logic [LANES-1:0][DIR_W-1:0] dir;
    logic [LANES-1:0][NRM_W-1:0] nrm;
    logic [IOR_W-1:0]            ni;
    logic [IOR_W-1:0]            nt;
    logic                        air;
  } front_t;

  typedef struct packed {
    front_t           f;
    logic [NIC_W-1:0] nic;
    logic             tir;
  } root_side_t;

  typedef struct packed {
    logic [IOR_W-1:0] nt;
    logic             air;
    logic             tir;
  } tail_t;

  typedef struct packed {
    logic [LANES-1:0][MAG_W-1:0] mag;
    logic [LANES-1:0]            neg;
    tail_t                       t;
  } len_side_t;

  typedef struct packed {
    logic [LANES-1:0] neg;
    tail_t            t;
    logic             zero;
  } div_side_t;

endpackage

[sv/rds_sqrt_pipe.sv]
module rds_sqrt_pipe #(
  parameter int IN_W   = 56,
  parameter int DATA_W = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rds_pkg::ctl_t         ctl_i,
  input  logic [IN_W-1:0]       rad_i,
  input  logic [DATA_W-1:0]     data_i,
  output logic                  valid_o,
  output logic [IN_W/2-1:0]     root_o,
  output logic [DATA_W-1:0]     data_o
);

  localparam int OUT_W = IN_W / 2;

  logic [IN_W-1:0]   rem_q  [OUT_W];
  logic [OUT_W-1:0]  root_q [OUT_W];
  logic [DATA_W-1:0] data_q [OUT_W];
  logic [OUT_W-1:0]  v_q;

  for (genvar i = 0; i < OUT_W; i++) begin : g_stage
    localparam int B = OUT_W - 1 - i;
    logic [IN_W-1:0]   rem_in;
    logic [OUT_W-1:0]  root_in;
    logic [DATA_W-1:0] data_in;
    logic [IN_W-1:0]   trial;

    if (i == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign data_in = data_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign data_in = data_q[i-1];
    end

    assign trial = (IN_W'(root_in) << (B + 1)) | (IN_W'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        if (rem_in >= trial) begin
          rem_q[i]  <= rem_in - trial;
          root_q[i] <= root_in | (OUT_W'(1) << B);
        end else begin
          rem_q[i]  <= rem_in;
          root_q[i] <= root_in;
        end
        data_q[i] <= data_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctl_i.en) begin
      v_q <= {v_q[OUT_W-2:0], ctl_i.valid};
    end
  end

  assign valid_o = v_q[OUT_W-1];
  assign root_o  = root_q[OUT_W-1];
  assign data_o  = data_q[OUT_W-1];

endmodule

[sv/rds_div_pipe.sv]
module rds_div_pipe #(
  parameter int DATA_W = 8
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  rds_pkg::ctl_t                                       ctl_i,
  input  logic [rds_pkg::LANES-1:0][rds_pkg::NUM_W-1:0]       num_i,
  input  logic [rds_pkg::LEN_W-1:0]                           den_i,
  input  logic [DATA_W-1:0]                                   data_i,
  output logic                                                valid_o,
  output logic [rds_pkg::LANES-1:0][rds_pkg::Q_W-1:0]         quo_o,
  output logic [DATA_W-1:0]                                   data_o
);

  localparam int QW = rds_pkg::Q_W;
  localparam int NW = rds_pkg::NUM_W;
  localparam int LN = rds_pkg::LANES;

  logic [LN-1:0][NW-1:0]           rem_q  [QW];
  logic [LN-1:0][QW-1:0]           quo_q  [QW];
  logic [rds_pkg::LEN_W-1:0]       den_q  [QW];
  logic [DATA_W-1:0]               data_q [QW];
  logic [QW-1:0]                   v_q;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int K = QW - 1 - i;
    logic [LN-1:0][NW-1:0]     rem_in;
    logic [LN-1:0][QW-1:0]     quo_in;
    logic [rds_pkg::LEN_W-1:0] den_in;
    logic [DATA_W-1:0]         data_in;
    logic [NW-1:0]             trial;

    if (i == 0) begin : g_first
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign data_in = data_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign den_in  = den_q[i-1];
      assign data_in = data_q[i-1];
    end

    assign trial = NW'(den_in) << K;

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        for (int j = 0; j < LN; j++) begin
          if (rem_in[j] >= trial) begin
            rem_q[i][j] <= rem_in[j] - trial;
            quo_q[i][j] <= quo_in[j] | (QW'(1) << K);
          end else begin
            rem_q[i][j] <= rem_in[j];
            quo_q[i][j] <= quo_in[j];
          end
        end
        den_q[i]  <= den_in;
        data_q[i] <= data_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctl_i.en) begin
      v_q <= {v_q[QW-2:0], ctl_i.valid};
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign data_o  = data_q[QW-1];

endmodule

[sv/refraction_direction_snell_unit.sv]
// Snell refraction of one ray per clock. A ray is taken in every cycle while
// the output skid register is empty; on its way to the output lie the two
// bit-per-stage square root pipelines (28 and 31 stages) and the 15-stage
// divider that normalizes the direction.
// Total internal reflection gives a zero direction with total_reflection set.
// Indices are to be written over the register port (material at 0x0, air at
// 0x4) only while no ray is in flight; the block itself does not enforce this.
module refraction_direction_snell_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // dir_x, dir_y, dir_z, normal_x, normal_y, normal_z, current_ior, pad
  input  logic [111:0] s_axis_tdata,
  // in_air
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_z, out_ior, pad
  output logic [63:0]  m_axis_tdata,
  // out_in_air, total_reflection
  output logic [1:0]   m_axis_tuser
);

  localparam logic REG_MATERIAL = 1'b0;
  localparam logic REG_AIR      = 1'b1;
  localparam int   LN = rds_pkg::LANES;

  logic [rds_pkg::IOR_W-1:0] material_q, air_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      material_q <= 14'd6144;
      air_q      <= 14'd4096;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_MATERIAL: material_q <= pwdata[13:0];
        REG_AIR:      air_q      <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MATERIAL: prdata = {18'd0, material_q};
      REG_AIR:      prdata = {18'd0, air_q};
      default:      prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  logic          k_v_q;
  logic          en;
  rds_pkg::ctl_t ctl;

  assign en            = !k_v_q;
  assign s_axis_tready = en;

  // front stages
  logic [7:0]            fv_q;
  rds_pkg::front_t       f_q [8];
  logic [LN-1:0][31:0]   s2_p_q;
  logic signed [33:0]    s3_c_q;
  logic signed [15:0]    s4_c14_q;
  logic [14:0]           s4_cmag_q;
  logic [28:0]           s5_c2_q;
  logic [27:0]           s5_nt2_q, s6_nt2_q, s7_nt2_q;
  logic [27:0]           s5_ni2_q, s6_ni2_q;
  logic [29:0]           nic_q [4];
  logic [28:0]           s6_s_q;
  logic [55:0]           s7_prod_q;
  logic [55:0]           s8_disc_q;
  logic                  s8_tir_q;

  rds_pkg::front_t       f_in;
  logic [33:0]           c_abs;
  logic [19:0]           c_rnd;
  logic [14:0]           c_mag;
  logic [56:0]           diff;

  always_comb begin
    f_in.ni  = s_axis_tdata[109:96];
    f_in.air = s_axis_tuser[0];
    f_in.nt  = s_axis_tuser[0] ? material_q : air_q;
    for (int j = 0; j < LN; j++) begin
      f_in.dir[j] = s_axis_tdata[16*j +: 16];
      f_in.nrm[j] = s_axis_tuser[0] ?
                    {s_axis_tdata[48+16*j+15], s_axis_tdata[48+16*j +: 16]} :
                    17'(-$signed({s_axis_tdata[48+16*j+15], s_axis_tdata[48+16*j +: 16]}));
    end
    c_abs = s3_c_q[33] ? 34'(-s3_c_q) : s3_c_q;
    c_rnd = 20'((c_abs + 34'd8192) >> 14);
    c_mag = (c_rnd > 20'd16384) ? 15'd16384 : c_rnd[14:0];
    diff  = {1'b0, s7_nt2_q, 28'd0} - {1'b0, s7_prod_q};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q[0] <= f_in;
      for (int i = 1; i < 8; i++) f_q[i] <= f_q[i-1];
      for (int j = 0; j < LN; j++) begin
        s2_p_q[j] <= 32'($signed(f_q[0].nrm[j]) * $signed(f_q[0].dir[j]));
      end
      s3_c_q    <= 34'(-($signed(s2_p_q[0]) + $signed(s2_p_q[1]) + $signed(s2_p_q[2])));
      s4_cmag_q <= c_mag;
      s4_c14_q  <= s3_c_q[33] ? 16'(-$signed({1'b0, c_mag})) : {1'b0, c_mag};
      s5_c2_q   <= 29'(s4_cmag_q * s4_cmag_q);
      s5_nt2_q  <= 28'(f_q[3].nt * f_q[3].nt);
      s5_ni2_q  <= 28'(f_q[3].ni * f_q[3].ni);
      nic_q[0]  <= 30'($signed({1'b0, f_q[3].ni}) * s4_c14_q);
      for (int i = 1; i < 4; i++) nic_q[i] <= nic_q[i-1];
      s6_s_q    <= 29'(29'h1000_0000 - s5_c2_q);
      s6_nt2_q  <= s5_nt2_q;
      s6_ni2_q  <= s5_ni2_q;
      s7_prod_q <= 56'(s6_ni2_q * s6_s_q);
      s7_nt2_q  <= s6_nt2_q;
      s8_tir_q  <= diff[56];
      s8_disc_q <= diff[56] ? '0 : diff[55:0];
    end
  end

  assign ctl.en    = en;
  assign ctl.valid = fv_q[7];

  rds_pkg::root_side_t side1_in, side1_out;
  logic                 sq1_v;
  logic [rds_pkg::R_W-1:0] sq1_r;

  assign side1_in.f   = f_q[7];
  assign side1_in.nic = nic_q[3];
  assign side1_in.tir = s8_tir_q;

  rds_sqrt_pipe #(
    .IN_W  (rds_pkg::DISC_W),
    .DATA_W($bits(rds_pkg::root_side_t))
  ) u_disc_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .rad_i  (s8_disc_q),
    .data_i (side1_in),
    .valid_o(sq1_v),
    .root_o (sq1_r),
    .data_o (side1_out)
  );

  // back stages
  logic [7:0]                mv_q;
  rds_pkg::root_side_t       s9_side_q;
  logic signed [30:0]        s9_a_q;
  logic [LN-1:0][30:0]       s10_pd_q;
  logic [LN-1:0][47:0]       s10_pa_q;
  rds_pkg::tail_t            t_q [7];
  logic [LN-1:0][47:0]       s11_v_q;
  logic [LN-1:0][46:0]       s12_mag_q, s13_mag_q;
  logic [LN-1:0]             neg_q [5];
  logic [4:0]                s13_sh_q;
  logic [LN-1:0][29:0]       s14_m_q, s15_m_q, s16_m_q;
  logic [LN-1:0][59:0]       s15_sq_q;
  logic [61:0]               s16_sum_q;

  logic [46:0] mag_or;
  logic [4:0]  sh;

  always_comb begin
    mag_or = s12_mag_q[0] | s12_mag_q[1] | s12_mag_q[2];
    sh = '0;
    for (int p = 30; p < 47; p++) begin
      if (mag_or[p]) sh = 5'(p - 29);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_side_q <= side1_out;
      s9_a_q    <= $signed({side1_out.nic[29], side1_out.nic}) - $signed({3'd0, sq1_r});
      for (int j = 0; j < LN; j++) begin
        s10_pd_q[j] <= 31'($signed({1'b0, s9_side_q.f.ni}) * $signed(s9_side_q.f.dir[j]));
        s10_pa_q[j] <= 48'(s9_a_q * $signed(s9_side_q.f.nrm[j]));
        s11_v_q[j]  <= {{3{s10_pd_q[j][30]}}, s10_pd_q[j], 14'd0} + s10_pa_q[j];
        s12_mag_q[j] <= s11_v_q[j][47] ? 47'(-s11_v_q[j]) : s11_v_q[j][46:0];
        s14_m_q[j]  <= 30'(s13_mag_q[j] >> s13_sh_q);
        s15_sq_q[j] <= 60'(s14_m_q[j] * s14_m_q[j]);
      end
      t_q[0].nt  <= s9_side_q.f.nt;
      t_q[0].air <= s9_side_q.f.air;
      t_q[0].tir <= s9_side_q.tir;
      for (int i = 1; i < 7; i++) t_q[i] <= t_q[i-1];
      neg_q[0] <= {s11_v_q[2][47], s11_v_q[1][47], s11_v_q[0][47]};
      for (int i = 1; i < 5; i++) neg_q[i] <= neg_q[i-1];
      s13_mag_q <= s12_mag_q;
      s13_sh_q  <= sh;
      s15_m_q   <= s14_m_q;
      s16_m_q   <= s15_m_q;
      s16_sum_q <= 62'(s15_sq_q[0]) + 62'(s15_sq_q[1]) + 62'(s15_sq_q[2]);
    end
  end

  rds_pkg::ctl_t             ctl2;
  rds_pkg::len_side_t        side2_in, side2_out;
  logic                      sq2_v;
  logic [rds_pkg::LEN_W-1:0] sq2_len;

  assign ctl2.en     = en;
  assign ctl2.valid  = mv_q[7];
  assign side2_in.mag = s16_m_q;
  assign side2_in.neg = neg_q[4];
  assign side2_in.t   = t_q[6];

  rds_sqrt_pipe #(
    .IN_W  (rds_pkg::SUM_W),
    .DATA_W($bits(rds_pkg::len_side_t))
  ) u_len_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl2),
    .rad_i  (s16_sum_q),
    .data_i (side2_in),
    .valid_o(sq2_v),
    .root_o (sq2_len),
    .data_o (side2_out)
  );

  logic                                       s17_v_q;
  logic [LN-1:0][rds_pkg::NUM_W-1:0]          s17_num_q;
  logic [rds_pkg::LEN_W-1:0]                  s17_den_q;
  rds_pkg::div_side_t                         s17_side_q, div_side;
  rds_pkg::ctl_t                              ctl3;
  logic                                       div_v;
  logic [LN-1:0][rds_pkg::Q_W-1:0]            quo;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < LN; j++) begin
        s17_num_q[j] <= {2'd0, side2_out.mag[j], 14'd0} + 46'(sq2_len >> 1);
      end
      s17_den_q       <= sq2_len;
      s17_side_q.neg  <= side2_out.neg;
      s17_side_q.t    <= side2_out.t;
      s17_side_q.zero <= (sq2_len == '0);
    end
  end

  assign ctl3.en    = en;
  assign ctl3.valid = s17_v_q;

  rds_div_pipe #(
    .DATA_W($bits(rds_pkg::div_side_t))
  ) u_norm_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl3),
    .num_i  (s17_num_q),
    .den_i  (s17_den_q),
    .data_i (s17_side_q),
    .valid_o(div_v),
    .quo_o  (quo),
    .data_o (div_side)
  );

  // result assembly, output register and skid
  logic        l_v_q;
  logic [63:0] l_data_q, l_data_d;
  logic [1:0]  l_user_q, l_user_d;
  logic [rds_pkg::Q_W-1:0] qc;
  logic        o_v_q;
  logic [63:0] o_data_q, k_data_q;
  logic [1:0]  o_user_q, k_user_q;

  always_comb begin
    l_data_d = '0;
    qc       = '0;
    for (int j = 0; j < LN; j++) begin
      qc = (quo[j] > rds_pkg::Q_ONE) ? rds_pkg::Q_ONE : quo[j];
      if (!div_side.t.tir && !div_side.zero) begin
        l_data_d[16*j +: 16] = div_side.neg[j] ? 16'(-$signed({1'b0, qc})) : {1'b0, qc};
      end
    end
    l_data_d[61:48] = div_side.t.nt;
    l_user_d        = {div_side.t.tir, !div_side.t.air};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_data_q <= l_data_d;
      l_user_q <= l_user_d;
      if (l_v_q) begin
        if (!o_v_q || m_axis_tready) begin
          o_data_q <= l_data_q;
          o_user_q <= l_user_q;
        end else begin
          k_data_q <= l_data_q;
          k_user_q <= l_user_q;
        end
      end
    end else if (m_axis_tready) begin
      o_data_q <= k_data_q;
      o_user_q <= k_user_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q    <= '0;
      mv_q    <= '0;
      s17_v_q <= 1'b0;
      l_v_q   <= 1'b0;
      o_v_q   <= 1'b0;
      k_v_q   <= 1'b0;
    end else begin
      if (en) begin
        fv_q    <= {fv_q[6:0], s_axis_tvalid};
        mv_q    <= {mv_q[6:0], sq1_v};
        s17_v_q <= sq2_v;
        l_v_q   <= div_v;
        if (l_v_q) begin
          if (!o_v_q || m_axis_tready) begin
            o_v_q <= 1'b1;
          end else begin
            k_v_q <= 1'b1;
          end
        end else if (m_axis_tready) begin
          o_v_q <= 1'b0;
        end
      end else if (m_axis_tready) begin
        k_v_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = o_data_q;
  assign m_axis_tuser  = o_user_q;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_v_q |-> o_v_q)
    else $error("skid holds a result while the output register is empty");

  a_skid_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(k_v_q) |-> $past(o_v_q && !m_axis_tready))
    else $error("skid filled without an output stall");

  a_tir_zero_dir : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[47:0] == 48'd0))
    else $error("total reflection with nonzero direction");

  a_dir_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
                       $signed(m_axis_tdata[15:0]) >= -16'sd16384))
    else $error("out_x beyond unit range");

endmodule
